// ===== rtl/pfds_pkg.sv =====
// shared types, constants and helpers for the pwm divider search
package pfds_pkg;

  // field and register widths
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned CODE_W      = 3;
  localparam int unsigned TOTAL_W     = 11;
  localparam int unsigned PERIOD_W    = 17;
  localparam int unsigned REG_W       = 16;
  localparam int unsigned FAST_W      = 4;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned STEP_CNT_W  = 5;

  // divider search defaults and limits
  localparam int unsigned DIV_CODES_DEF = 8;
  localparam logic [TOTAL_W-1:0]  DIV_BOUND    = TOTAL_W'(1792);
  localparam logic [WORD_W-1:0]   PERIOD_LIMIT = WORD_W'(65536);
  localparam logic [WORD_W-1:0]   CLOCK_RESET  = WORD_W'(125000000);
  localparam logic [WORD_W-1:0]   MAX_OUT_RESET = WORD_W'(62500000);
  localparam logic [WORD_W-1:0]   FREQ_RESET   = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_CLOCK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_OUTPUT  = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_EVAL,
    ST_DONE
  } state_t;

  // high-speed divider ratio: 1 for code 0, else twice the code
  function automatic logic [FAST_W-1:0] fast_divide(input logic [CODE_W-1:0] code);
    logic [FAST_W-1:0] ratio;
    if (code == '0) begin
      ratio = FAST_W'(1);
    end else begin
      ratio = {code, 1'b0};
    end
    return ratio;
  endfunction

endpackage

// ===== rtl/pwm_frequency_divider_search.sv =====
// pwm divider search: picks prescaler codes and period for a polled frequency
//
// Input channel (in_valid/in_stall/in_freq_hz) takes one polled frequency.
// A frequency equal to the last one seen produces no result; after reset the
// last value is all ones. Zero gives a force-low result right away. Any other
// value is capped at max_output_hz and each divider pair is tried in turn.
// A pair is skipped in its setup state when the product overflows, the
// divisor is zero or its total divide is no better; a pair that is tried
// goes through one setup, a bit-serial restoring divider that produces one
// quotient bit per cycle, and one evaluation step. Each divider has 8 codes
// by default.
// The result (out_valid/out_stall and the out_ fields) sits in an output
// register; in_stall is high while a search runs or while a finished search
// waits for that register to empty, and low again once the result is stored,
// so the next frequency is taken while the receiver still stalls.
// Configuration writes (cfg_we/cfg_index/cfg_wdata) take effect at once and
// belong only in idle periods, with no search running.
// Synchronous reset restores the default clock and cap and empties the
// output register.
module pwm_frequency_divider_search #(
  parameter int unsigned DIV_CODES = pfds_pkg::DIV_CODES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [pfds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pfds_pkg::WORD_W-1:0]      cfg_wdata,
  // frequency input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pfds_pkg::WORD_W-1:0]      in_freq_hz,
  // result output
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_force_low,
  output logic                             out_apply,
  output logic [pfds_pkg::REG_W-1:0]       out_period_value,
  output logic [pfds_pkg::REG_W-1:0]       out_compare_value,
  output logic [pfds_pkg::CODE_W-1:0]      out_clock_div_code,
  output logic [pfds_pkg::CODE_W-1:0]      out_fast_div_code
);

  localparam int unsigned WORD_W   = pfds_pkg::WORD_W;
  localparam int unsigned CODE_W   = pfds_pkg::CODE_W;
  localparam int unsigned TOTAL_W  = pfds_pkg::TOTAL_W;
  localparam int unsigned PERIOD_W = pfds_pkg::PERIOD_W;
  localparam int unsigned REG_W    = pfds_pkg::REG_W;
  localparam int unsigned FAST_W   = pfds_pkg::FAST_W;
  localparam int unsigned CNT_W    = pfds_pkg::STEP_CNT_W;
  localparam int unsigned MUL_W    = WORD_W + FAST_W;
  localparam int unsigned SHIFT_W  = MUL_W + (1 << CODE_W) - 1;
  localparam logic [CODE_W-1:0] CODE_LAST = CODE_W'(DIV_CODES - 1);
  localparam logic [CNT_W-1:0]  STEP_LAST = CNT_W'(WORD_W - 1);

  // state and registers
  pfds_pkg::state_t state_r, state_nxt;
  logic [WORD_W-1:0]   clk_hz_r, clk_hz_nxt;
  logic [WORD_W-1:0]   max_hz_r, max_hz_nxt;
  logic [WORD_W-1:0]   prev_r, prev_nxt;
  logic [WORD_W-1:0]   freq_r, freq_nxt;
  logic [CODE_W-1:0]   c_r, c_nxt;
  logic [CODE_W-1:0]   h_r, h_nxt;
  logic [TOTAL_W-1:0]  best_total_r, best_total_nxt;
  logic [PERIOD_W-1:0] best_period_r, best_period_nxt;
  logic [CODE_W-1:0]   best_c_r, best_c_nxt;
  logic [CODE_W-1:0]   best_h_r, best_h_nxt;
  logic                force_r, force_nxt;
  logic [WORD_W-1:0]   div_r, div_nxt;
  logic [WORD_W-1:0]   rem_r, rem_nxt;
  logic [WORD_W-1:0]   dvd_r, dvd_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_force_r, out_force_nxt;
  logic                out_apply_r, out_apply_nxt;
  logic [REG_W-1:0]    out_period_r, out_period_nxt;
  logic [REG_W-1:0]    out_compare_r, out_compare_nxt;
  logic [CODE_W-1:0]   out_clk_code_r, out_clk_code_nxt;
  logic [CODE_W-1:0]   out_fast_code_r, out_fast_code_nxt;

  // per-pair arithmetic
  logic [FAST_W-1:0]  fast_ratio;
  logic [TOTAL_W-1:0] pair_total;
  logic [MUL_W-1:0]   freq_mul;
  logic [SHIFT_W-1:0] divisor_full;
  logic               pair_skip;
  logic               pair_last;
  logic [WORD_W:0]    rem_shift;
  logic [WORD_W:0]    rem_diff;
  logic               rem_ge;
  logic               in_xfer;
  logic               out_xfer;
  logic [PERIOD_W-1:0] period_m1;

  assign fast_ratio   = pfds_pkg::fast_divide(h_r);
  assign pair_total   = TOTAL_W'(fast_ratio) << c_r;
  assign freq_mul     = MUL_W'(freq_r) * MUL_W'(fast_ratio);
  assign divisor_full = SHIFT_W'(freq_mul) << c_r;
  assign pair_skip    = (|divisor_full[SHIFT_W-1:WORD_W])
                      || (divisor_full[WORD_W-1:0] == '0)
                      || (pair_total >= best_total_r);
  assign pair_last    = (c_r == CODE_LAST) && (h_r == CODE_LAST);

  // one restoring divide step
  assign rem_shift = {rem_r, dvd_r[WORD_W-1]};
  assign rem_diff  = rem_shift - {1'b0, div_r};
  assign rem_ge    = !rem_diff[WORD_W];

  assign period_m1 = best_period_r - PERIOD_W'(1);

  assign in_stall = (state_r != pfds_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  // sequencer and datapath next values
  always_comb begin
    state_nxt         = state_r;
    clk_hz_nxt        = clk_hz_r;
    max_hz_nxt        = max_hz_r;
    prev_nxt          = prev_r;
    freq_nxt          = freq_r;
    c_nxt             = c_r;
    h_nxt             = h_r;
    best_total_nxt    = best_total_r;
    best_period_nxt   = best_period_r;
    best_c_nxt        = best_c_r;
    best_h_nxt        = best_h_r;
    force_nxt         = force_r;
    div_nxt           = div_r;
    rem_nxt           = rem_r;
    dvd_nxt           = dvd_r;
    cnt_nxt           = cnt_r;
    out_valid_nxt     = out_xfer ? 1'b0 : out_valid_r;
    out_force_nxt     = out_force_r;
    out_apply_nxt     = out_apply_r;
    out_period_nxt    = out_period_r;
    out_compare_nxt   = out_compare_r;
    out_clk_code_nxt  = out_clk_code_r;
    out_fast_code_nxt = out_fast_code_r;

    // configuration writes
    if (cfg_we) begin
      case (cfg_index)
        pfds_pkg::CFG_INPUT_CLOCK: clk_hz_nxt = cfg_wdata;
        pfds_pkg::CFG_MAX_OUTPUT:  max_hz_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      pfds_pkg::ST_IDLE: begin
        if (in_xfer && (in_freq_hz != prev_r)) begin
          prev_nxt        = in_freq_hz;
          freq_nxt        = (in_freq_hz > max_hz_r) ? max_hz_r : in_freq_hz;
          c_nxt           = '0;
          h_nxt           = '0;
          best_total_nxt  = pfds_pkg::DIV_BOUND;
          best_period_nxt = '0;
          best_c_nxt      = '0;
          best_h_nxt      = '0;
          if (in_freq_hz == '0) begin
            force_nxt = 1'b1;
            state_nxt = pfds_pkg::ST_DONE;
          end else begin
            force_nxt = 1'b0;
            state_nxt = pfds_pkg::ST_PREP;
          end
        end
      end

      pfds_pkg::ST_PREP: begin
        if (pair_skip) begin
          if (pair_last) begin
            state_nxt = pfds_pkg::ST_DONE;
          end else if (h_r == CODE_LAST) begin
            h_nxt = '0;
            c_nxt = c_r + CODE_W'(1);
          end else begin
            h_nxt = h_r + CODE_W'(1);
          end
        end else begin
          div_nxt   = divisor_full[WORD_W-1:0];
          rem_nxt   = '0;
          dvd_nxt   = clk_hz_r;
          cnt_nxt   = '0;
          state_nxt = pfds_pkg::ST_DIV;
        end
      end

      // quotient bits shift in at the bottom of the dividend register
      pfds_pkg::ST_DIV: begin
        rem_nxt = rem_ge ? rem_diff[WORD_W-1:0] : rem_shift[WORD_W-1:0];
        dvd_nxt = {dvd_r[WORD_W-2:0], rem_ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == STEP_LAST) begin
          state_nxt = pfds_pkg::ST_EVAL;
        end
      end

      pfds_pkg::ST_EVAL: begin
        if (dvd_r <= pfds_pkg::PERIOD_LIMIT) begin
          best_total_nxt  = pair_total;
          best_period_nxt = dvd_r[PERIOD_W-1:0];
          best_c_nxt      = c_r;
          best_h_nxt      = h_r;
        end
        if (pair_last) begin
          state_nxt = pfds_pkg::ST_DONE;
        end else begin
          state_nxt = pfds_pkg::ST_PREP;
          if (h_r == CODE_LAST) begin
            h_nxt = '0;
            c_nxt = c_r + CODE_W'(1);
          end else begin
            h_nxt = h_r + CODE_W'(1);
          end
        end
      end

      // load the output register once it is free
      pfds_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_force_nxt = force_r;
          if (best_period_r != '0) begin
            out_apply_nxt     = 1'b1;
            out_period_nxt    = period_m1[REG_W-1:0];
            out_compare_nxt   = best_period_r[REG_W:1];
            out_clk_code_nxt  = best_c_r;
            out_fast_code_nxt = best_h_r;
          end else begin
            out_apply_nxt     = 1'b0;
            out_period_nxt    = '0;
            out_compare_nxt   = '0;
            out_clk_code_nxt  = '0;
            out_fast_code_nxt = '0;
          end
          state_nxt = pfds_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pfds_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfds_pkg::ST_IDLE;
      clk_hz_r    <= pfds_pkg::CLOCK_RESET;
      max_hz_r    <= pfds_pkg::MAX_OUT_RESET;
      prev_r      <= pfds_pkg::FREQ_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clk_hz_r    <= clk_hz_nxt;
      max_hz_r    <= max_hz_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    freq_r          <= freq_nxt;
    c_r             <= c_nxt;
    h_r             <= h_nxt;
    best_total_r    <= best_total_nxt;
    best_period_r   <= best_period_nxt;
    best_c_r        <= best_c_nxt;
    best_h_r        <= best_h_nxt;
    force_r         <= force_nxt;
    div_r           <= div_nxt;
    rem_r           <= rem_nxt;
    dvd_r           <= dvd_nxt;
    cnt_r           <= cnt_nxt;
    out_force_r     <= out_force_nxt;
    out_apply_r     <= out_apply_nxt;
    out_period_r    <= out_period_nxt;
    out_compare_r   <= out_compare_nxt;
    out_clk_code_r  <= out_clk_code_nxt;
    out_fast_code_r <= out_fast_code_nxt;
  end

  // result ports
  assign out_valid          = out_valid_r;
  assign out_force_low      = out_force_r;
  assign out_apply          = out_apply_r;
  assign out_period_value   = out_period_r;
  assign out_compare_value  = out_compare_r;
  assign out_clock_div_code = out_clk_code_r;
  assign out_fast_div_code  = out_fast_code_r;

endmodule
